### design/bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divisor search package
// Shared widths and constants for the divisor search and its checker.
// ----------------------------------------------------------------------------
package bds_pkg;
  localparam int unsigned DivW      = 48;
  localparam int unsigned RatioW    = 16;
  localparam logic [15:0] RatioMax  = 16'hFFFF;
  localparam logic [13:0] TolReset  = 14'd200;
  localparam logic [13:0] RatioUnit = 14'd10000;
endpackage

### design/bds_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divisor search serial divider
// Restoring divider, one quotient bit per cycle, unsigned 48-bit operands.
// ----------------------------------------------------------------------------
module bds_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [47:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] rem;
  logic [47:0] den;
  logic [5:0]  count;
  logic        busy;
  logic [48:0] trial;

  // Shift in one dividend bit and try the subtraction.
  assign trial = {rem, quotient[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
        count    <= 6'd48;
      end else if (busy) begin
        if (!trial[48]) begin
          rem      <= trial[47:0];
          quotient <= {quotient[46:0], 1'b1};
        end else begin
          rem      <= {rem[46:0], quotient[47]};
          quotient <= {quotient[46:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### design/baud_divisor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divisor search
// Finds the USART baud select mantissa and scale exponent for a clock and rate.
// ----------------------------------------------------------------------------
// Every try uses the one 48-bit serial divider up to three times (mantissa,
// real rate, ratio); up to 15 tries run at normal speed and, when the best
// deviation misses the tolerance, up to 15 more at double speed. The block
// holds in_stall high from acceptance until the result transfer completes.
module baud_divisor_search #(
  parameter int unsigned MANTISSA_LIMIT = 4095,
  parameter int unsigned SCALE_STEPS    = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [24:0] periph_clock,
  input  logic [20:0] wanted_baud,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] divisor_mantissa,
  output logic signed [3:0] divisor_exponent,
  output logic        double_speed,
  output logic [15:0] deviation,
  output logic        found
);
  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_TRY, S_MANT, S_REAL, S_RAT, S_CONS, S_END, S_OUT
  } state_t;

  localparam logic [47:0] Limit = 48'(MANTISSA_LIMIT);
  localparam logic [2:0]  Steps = 3'(SCALE_STEPS);

  state_t      state;
  logic [13:0] tolerance;
  logic [24:0] pclk;
  logic [20:0] want;
  logic        dbl;
  logic        neg;
  logic [2:0]  step;
  logic [47:0] mant;
  logic [47:0] real_rate;
  logic        ok;
  logic [15:0] ratio;
  logic [11:0] bmant;
  logic [3:0]  bexp;
  logic        p_ok;
  logic [15:0] p_ratio;
  logic [11:0] p_mant;
  logic [3:0]  p_exp;

  logic        div_start;
  logic [47:0] div_a;
  logic [47:0] div_b;
  logic        div_done;
  logic [47:0] div_q;

  logic [2:0]  base;
  logic [47:0] deno;
  logic [47:0] twice;
  logic [47:0] ndeno;
  logic        try_stop;
  logic [47:0] try_a;
  logic [47:0] try_b;
  logic [47:0] real_a;
  logic [47:0] real_b;
  logic [47:0] rate_small;
  logic [21:0] rate_big;
  logic [47:0] rat_a;
  logic        pass_good;

  bds_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  function automatic logic [16:0] RatioUnitSum(input logic [13:0] t);
    RatioUnitSum = {3'd0, bds_pkg::RatioUnit} + {3'd0, t};
  endfunction

  // Operand set-up for the current try.
  always_comb begin
    base  = dbl ? 3'd3 : 3'd4;
    twice = {22'd0, pclk, 1'b0};
    deno  = {27'd0, want} << ({1'b0, base} + {1'b0, step});
    ndeno = {27'd0, want} << (base - 3'd1);
    if (!neg) begin
      try_stop = twice <= deno;
      try_a    = twice - deno;
      try_b    = deno << 1;
      real_a   = {23'd0, pclk} >> step;
      real_b   = (mant + 48'd1) << base;
    end else begin
      try_stop = {23'd0, pclk} < (ndeno << 1);
      try_a    = (({23'd0, pclk} - (ndeno << 1)) << step) + ndeno;
      try_b    = ndeno << 1;
      real_a   = {23'd0, pclk} << step;
      real_b   = ({36'd0, mant[11:0]} + (48'd1 << step)) << base;
    end
    // The real rate never exceeds the clock over 8, so it fits in 22 bits.
    rate_small = ({27'd0, want} < div_q) ? {27'd0, want} : div_q;
    rate_big   = ({27'd0, want} < div_q) ? div_q[21:0] : {1'b0, want};
    rat_a      = {12'd0, {14'd0, rate_big} * 36'd10000};
    pass_good = ok && ({1'b0, ratio} <= 17'(RatioUnitSum(tolerance)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tolerance <= bds_pkg::TolReset;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) tolerance <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pclk  <= periph_clock;
            want  <= wanted_baud;
            dbl   <= 1'b0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          ok    <= 1'b0;
          ratio <= bds_pkg::RatioMax;
          bmant <= '0;
          bexp  <= '0;
          neg   <= 1'b0;
          step  <= '0;
          state <= (want == '0) ? S_END : S_TRY;
        end
        S_TRY: begin
          if (try_stop) begin
            if (!neg) begin
              neg  <= 1'b1;
              step <= 3'd1;
            end else begin
              state <= S_END;
            end
          end else begin
            div_a     <= try_a;
            div_b     <= try_b;
            div_start <= 1'b1;
            state     <= S_MANT;
          end
        end
        S_MANT: begin
          if (div_done) begin
            mant <= div_q;
            if (div_q >= Limit) begin
              if (neg) state <= S_END;
              else state <= S_CONS;
              real_rate <= '0;
            end else begin
              state <= S_REAL;
            end
          end
        end
        S_REAL: begin
          // Issued in the cycle after the mantissa is registered, so real_b sees it.
          div_a     <= real_a;
          div_b     <= real_b;
          div_start <= 1'b1;
          state     <= S_RAT;
          real_rate <= '1;
        end
        S_RAT: begin
          if (div_done) begin
            real_rate <= div_q;
            if (div_q == '0) begin
              state <= S_CONS;
            end else begin
              state <= S_CONS;
              div_start <= 1'b1;
              div_b     <= rate_small;
              div_a     <= rat_a;
              real_rate <= '1;
              mant      <= mant;
            end
          end
        end
        S_CONS: begin
          if (real_rate == '0 || div_done) begin
            if (div_done && (div_q < {32'd0, ratio})) begin
              ratio <= div_q[15:0];
              bmant <= mant[11:0];
              bexp  <= neg ? 4'(-$signed({1'b0, step})) : {1'b0, step};
              ok    <= 1'b1;
            end
            // Advance to the next exponent.
            if (step == Steps) begin
              if (!neg) begin
                neg  <= 1'b1;
                step <= 3'd1;
              end else begin
                state <= S_END;
              end
            end else begin
              step <= step + 3'd1;
            end
            if (!(step == Steps && neg)) state <= S_TRY;
          end
        end
        S_END: begin
          if (!dbl) begin
            p_ok    <= ok;
            p_ratio <= ratio;
            p_mant  <= bmant;
            p_exp   <= bexp;
            if (pass_good) begin
              state <= S_OUT;
              out_valid <= 1'b1;
              found <= ok;
              divisor_mantissa <= bmant;
              divisor_exponent <= bexp;
              double_speed <= 1'b0;
              deviation <= ratio - 16'(bds_pkg::RatioUnit);
            end else begin
              dbl   <= 1'b1;
              state <= S_PASS;
            end
          end else begin
            state     <= S_OUT;
            out_valid <= 1'b1;
            if (ok) begin
              found <= 1'b1;
              divisor_mantissa <= bmant;
              divisor_exponent <= bexp;
              double_speed <= 1'b1;
              deviation <= ratio - 16'(bds_pkg::RatioUnit);
            end else if (p_ok) begin
              found <= 1'b1;
              divisor_mantissa <= p_mant;
              divisor_exponent <= p_exp;
              double_speed <= 1'b0;
              deviation <= p_ratio - 16'(bds_pkg::RatioUnit);
            end else begin
              found <= 1'b0;
              divisor_mantissa <= '0;
              divisor_exponent <= '0;
              double_speed <= 1'b0;
              deviation <= '0;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
endmodule

### tb/sv/baud_divisor_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divisor search checker
// Watches both channels, predicts each divisor choice and compares results.
// ----------------------------------------------------------------------------
module baud_divisor_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [24:0] periph_clock,
  input  logic [20:0] wanted_baud,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] divisor_mantissa,
  input  logic signed [3:0] divisor_exponent,
  input  logic        double_speed,
  input  logic [15:0] deviation,
  input  logic        found,
  output int          errors,
  output int          pending
);
  localparam int unsigned MantLimit = 4095;
  localparam int unsigned Steps     = 7;

  typedef struct packed {
    logic [11:0] mant;
    logic [3:0]  expo;
    logic        dbl;
    logic [15:0] dev;
    logic        fnd;
  } divisor_t;

  typedef struct {
    bit          ok;
    longint      ratio;
    longint      mant;
    int          expo;
  } trial_t;

  divisor_t    divisor_queue[$];
  logic [13:0] tol;

  function automatic longint ratio_calc(longint want, longint real_rate);
    longint r;
    if (want < real_rate) r = (real_rate * 10000) / want;
    else r = (want * 10000) / real_rate;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic void weigh(ref trial_t p, input longint want, input longint real_rate,
                                input longint mant, input int expo);
    longint r;
    if (real_rate == 0) return;
    r = ratio_calc(want, real_rate);
    if (r < p.ratio) begin
      p.ratio = r;
      p.mant = mant;
      p.expo = expo;
      p.ok = 1'b1;
    end
  endfunction

  function automatic trial_t scan(longint pclk, longint want, int dbl);
    trial_t p;
    int     base;
    longint deno, twice, mant, real_rate, num;
    base = 4 - dbl;
    p.ok = 1'b0;
    p.ratio = 65535;
    p.mant = 0;
    p.expo = 0;
    if (want == 0) return p;
    // Positive exponents.
    for (int s = 0; s <= Steps; s++) begin
      deno = want << (base + s);
      twice = pclk << 1;
      if (twice <= deno) break;
      mant = (twice - deno) / (deno << 1);
      if (mant >= MantLimit) continue;
      real_rate = (pclk >> s) / ((mant + 1) << base);
      weigh(p, want, real_rate, mant, s);
    end
    // Negative exponents.
    for (int s = 1; s <= Steps; s++) begin
      deno = want << (base - 1);
      if (pclk < (deno << 1)) break;
      num = (((pclk - (deno << 1)) << s) + deno) / (deno << 1);
      if (num >= MantLimit) break;
      mant = num & 64'hFFF;
      real_rate = (pclk << s) / ((mant + (64'd1 << s)) << base);
      weigh(p, want, real_rate, mant, -s);
    end
    return p;
  endfunction

  function automatic divisor_t choose_divisor(logic [24:0] pc, logic [20:0] wb);
    trial_t   p, q;
    divisor_t d;
    bit       dbl;
    dbl = 1'b0;
    p = scan(longint'(pc), longint'(wb), 0);
    if (!(p.ok && p.ratio <= 10000 + longint'(tol))) begin
      q = scan(longint'(pc), longint'(wb), 1);
      if (q.ok) begin
        p = q;
        dbl = 1'b1;
      end
    end
    d = '0;
    if (p.ok) begin
      d.mant = p.mant[11:0];
      d.expo = p.expo[3:0];
      d.dbl = dbl;
      d.dev = 16'(p.ratio - 10000);
      d.fnd = 1'b1;
    end
    return d;
  endfunction

  assign pending = divisor_queue.size();

  // Track configuration, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    divisor_t e, a;
    if (rst) begin
      tol <= bds_pkg::TolReset;
      errors <= 0;
      divisor_queue.delete();
    end else begin
      if (cfg_we) tol <= cfg_wdata;
      if (in_valid && !in_stall) divisor_queue.push_back(choose_divisor(periph_clock, wanted_baud));
      if (out_valid && !out_stall) begin
        a = {divisor_mantissa, divisor_exponent, double_speed, deviation, found};
        if (divisor_queue.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer %h", a);
          errors <= errors + 1;
        end else begin
          e = divisor_queue.pop_front();
          if (e !== a) begin
            if (errors < 10)
              $display("mismatch: exp m=%0d e=%0d d=%0b dev=%0d f=%0b, got m=%0d e=%0d d=%0b dev=%0d f=%0b",
                       e.mant, $signed(e.expo), e.dbl, e.dev, e.fnd,
                       a.mant, $signed(a.expo), a.dbl, a.dev, a.fnd);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/baud_divisor_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baud divisor search testbench
// Drives directed and random clock/baud pairs across several tolerances.
// ----------------------------------------------------------------------------
module baud_divisor_search_tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [13:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [24:0] periph_clock = '0;
  logic [20:0] wanted_baud = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] divisor_mantissa;
  logic signed [3:0] divisor_exponent;
  logic        double_speed;
  logic [15:0] deviation;
  logic        found;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  localparam int WatchLimit = 40000;

  always #5 clk = ~clk;

  baud_divisor_search dut (.*);
  baud_divisor_search_checker chk (.*);

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("baud_divisor_search_tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls in random bursts, plus one long hold-off.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (6000) @(negedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
        @(negedge clk);
      end else if (!calm && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
        @(negedge clk);
      end else @(negedge clk);
    end
  end

  // Valid stays high after a transfer; it drops only while the sender idles.
  task automatic send_rate(logic [24:0] pc, logic [20:0] wb);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    periph_clock <= pc;
    wanted_baud <= wb;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_and_set(logic [13:0] t);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random();
    logic [24:0] pc;
    logic [20:0] wb;
    case ($urandom_range(4))
      0: begin
        pc = 25'($urandom_range(32000000, 1000000));
        wb = 21'($urandom_range(115200, 300));
      end
      1: begin
        pc = 25'($urandom_range(32000000, 128));
        wb = 21'($urandom_range(2000000, 1));
      end
      2: begin
        pc = 25'($urandom);
        wb = 21'($urandom);
      end
      3: begin
        pc = 25'($urandom_range(4000000, 128));
        wb = 21'($urandom_range(pc / 8 + 1, 1));
      end
      default: begin
        pc = 25'($urandom_range(32000000, 8000000));
        wb = 21'($urandom_range(2000000, 250000));
      end
    endcase
    send_rate(pc, wb);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed cases at the reset tolerance.
    send_rate(25'd32000000, 21'd115200);
    send_rate(25'd16000000, 21'd9600);
    send_rate(25'd128, 21'd1);
    send_rate(25'd128, 21'd2000000);
    send_rate(25'h1FFFFFF, 21'h1FFFFF);
    send_rate(25'h1FFFFFF, 21'd1);
    send_rate(25'd32000000, 21'd0);
    send_rate(25'd0, 21'd9600);
    send_rate(25'd32000000, 21'd2000000);
    send_rate(25'd1000, 21'd300);
    send_rate(25'd2000000, 21'd115200);
    send_rate(25'd32000000, 21'd1);
    send_rate(25'd8000000, 21'd500000);
    drain_and_set(14'd0);
    send_rate(25'd14745600, 21'd115200);
    send_rate(25'd32000000, 21'd921600);
    send_rate(25'd2000000, 21'd57600);
    drain_and_set(14'd10000);
    send_rate(25'd32000000, 21'd921600);
    send_rate(25'd128, 21'd100);
    drain_and_set(14'h3FFF);
    send_rate(25'd2000000, 21'd57600);
    drain_and_set(14'd0);
    // Random phase at zero tolerance, with a long receiver hold-off.
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_random();
    drain_and_set(14'd200);
    for (int i = 0; i < 40; i++) send_random();
    // Sender pauses until every result has come.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    drain_and_set(14'($urandom_range(10000)));
    for (int i = 0; i < 35; i++) send_random();
    drain_and_set(14'd50);
    calm = 1'b1;
    for (int i = 0; i < 35; i++) send_random();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("baud_divisor_search_tb: done, clean");
    else $display("baud_divisor_search_tb: done, errors");
    $finish;
  end
endmodule

### filelist.f
design/bds_pkg.sv
design/bds_divider.sv
design/baud_divisor_search.sv
tb/sv/baud_divisor_search_checker.sv
tb/sv/baud_divisor_search_tb.sv
